FILE: sv/mmhv_pkg.sv
// Shared package for the magic multiply hash verifier.
// Holds default sizes, result codes and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package mmhv_pkg;

    // Default sizes, handed to the top level parameters
    localparam int MAX_INDEX_BITS_DEF = 12;
    localparam int PAD_BITS_DEF       = 0;
    localparam int STAMP_WIDTH_DEF    = 22;

    // Fixed field widths
    localparam int MAGIC_W = 64;
    localparam int COLL_W  = 12;

    // Result kinds loaded into the output register
    localparam logic [1:0] RES_ZERO = 2'd0;  // zero candidate, rejected without a scan
    localparam logic [1:0] RES_HIT  = 2'd1;  // collision found
    localparam logic [1:0] RES_PASS = 2'd2;  // every subset mapped to a distinct index

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       item_load;   // capture candidate and mask, reset scan state
        logic       scan_step;   // take the next lowest set bit of the mask
        logic       stamp_adv;   // move to a fresh stamp
        logic       clr_step;    // zero one table entry
        logic       mul_lo;      // multiply low x low
        logic       mul_mid;     // accumulate high x low
        logic       mul_hi;      // accumulate low x high
        logic       tbl_rd;      // read the table at the computed index
        logic       tbl_wr;      // claim the index with the current stamp
        logic       subset_adv;  // step to the next subset
        logic       res_load;    // load the output register
        logic [1:0] res_kind;
    } mmhv_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic magic_zero;
        logic scan_done;
        logic stamp_wrap;
        logic clr_last;
        logic hit;
        logic subset_last;
    } mmhv_stat_t;

endpackage

`default_nettype wire

FILE: sv/magic_multiply_hash_verifier.sv
// A zero candidate is rejected without a scan; otherwise the block scans the used mask
// bits, then checks each subset with the shared 32x32 multiplier (3 passes) and the
// table read/check, with early exit on collision. One candidate at a time; a stamp
// wrap adds a clear of all 2^(MAX_INDEX_BITS+PAD_BITS) table entries. After reset the
// same clear pass (4096 entries by default) runs with s_ready low; APB writes are
// taken throughout.
`default_nettype none

module magic_multiply_hash_verifier import mmhv_pkg::*; #(
    parameter int MAX_INDEX_BITS = MAX_INDEX_BITS_DEF,
    parameter int PAD_BITS       = PAD_BITS_DEF,
    parameter int STAMP_WIDTH    = STAMP_WIDTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // APB configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [63:0]        pwdata,
    output logic [63:0]             prdata,
    output logic                    pready,
    // Candidate input
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [MAGIC_W-1:0] s_candidate_magic,
    // Result output
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_accepted,
    output logic [MAGIC_W-1:0]      m_accepted_magic,
    output logic [COLL_W-1:0]       m_collision_subset
);

    logic [MAGIC_W-1:0] relevant_mask_reg;
    logic               cfg_wr;
    mmhv_cmd_t          cmd;
    mmhv_stat_t         st;

    // Register file: relevant_mask at byte address 0
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            relevant_mask_reg <= '0;
        end else if (cfg_wr) begin
            relevant_mask_reg <= pwdata;
        end
    end

    assign prdata = paddr[3] ? 64'd0 : relevant_mask_reg;

    mmhv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .st      (st),
        .cmd     (cmd)
    );

    mmhv_datapath #(
        .MAX_INDEX_BITS (MAX_INDEX_BITS),
        .PAD_BITS       (PAD_BITS),
        .STAMP_WIDTH    (STAMP_WIDTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .relevant_mask (relevant_mask_reg),
        .in_magic      (s_candidate_magic),
        .cmd           (cmd),
        .st            (st),
        .res_accepted  (m_accepted),
        .res_magic     (m_accepted_magic),
        .res_collision (m_collision_subset)
    );

endmodule

`default_nettype wire

FILE: sv/mmhv_datapath.sv
// Datapath of the magic multiply hash verifier: mask scan, subset walk,
// shared 32x32 multiplier, stamp table memory and result register.
// Depends on mmhv_pkg.
`default_nettype none

module mmhv_datapath import mmhv_pkg::*; #(
    parameter int MAX_INDEX_BITS = MAX_INDEX_BITS_DEF,
    parameter int PAD_BITS       = PAD_BITS_DEF,
    parameter int STAMP_WIDTH    = STAMP_WIDTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [MAGIC_W-1:0] relevant_mask,
    input  wire logic [MAGIC_W-1:0] in_magic,
    input  wire mmhv_cmd_t          cmd,
    output mmhv_stat_t              st,
    output logic                    res_accepted,
    output logic [MAGIC_W-1:0]      res_magic,
    output logic [COLL_W-1:0]       res_collision
);

    localparam int TABLE_BITS = MAX_INDEX_BITS + PAD_BITS;
    localparam int TABLE_SIZE = 1 << TABLE_BITS;
    localparam int CNT_W      = $clog2(MAX_INDEX_BITS + 1);
    localparam int SH_W       = $clog2(TABLE_BITS + 1);

    logic [MAGIC_W-1:0]        magic_reg;
    logic [MAGIC_W-1:0]        rem_reg;
    logic [MAGIC_W-1:0]        eff_reg;
    logic [CNT_W-1:0]          n_reg;
    logic [MAGIC_W-1:0]        subset_reg;
    logic [MAX_INDEX_BITS-1:0] j_reg;
    logic [STAMP_WIDTH-1:0]    stamp_reg;
    logic [31:0]               acc_reg;
    logic [TABLE_BITS-1:0]     idx_reg;
    logic [TABLE_BITS-1:0]     clr_addr_reg;
    logic [STAMP_WIDTH-1:0]    rd_data_reg;
    logic                      res_accepted_reg;
    logic [MAGIC_W-1:0]        res_magic_reg;
    logic [COLL_W-1:0]         res_collision_reg;

    logic [STAMP_WIDTH-1:0]    tbl_mem [TABLE_SIZE];

    logic [MAGIC_W-1:0]        low_bit;
    logic [MAGIC_W-1:0]        subset_next;
    logic [31:0]               mul_a;
    logic [31:0]               mul_b;
    logic [63:0]               mul_p;
    logic [31:0]               acc_next;
    logic [TABLE_BITS-1:0]     idx_top;
    logic [SH_W-1:0]           idx_shamt;
    logic [TABLE_BITS-1:0]     idx_calc;

    // Lowest remaining mask bit, and next subset in deposit order
    assign low_bit     = rem_reg & (~rem_reg + 64'd1);
    assign subset_next = (subset_reg - eff_reg) & eff_reg;

    // Shared multiplier; the low x low pass keeps product bits 63:32, the cross passes add bits 31:0
    always_comb begin
        mul_a = magic_reg[31:0];
        mul_b = subset_reg[31:0];
        if (cmd.mul_mid) begin
            mul_a = magic_reg[63:32];
        end else if (cmd.mul_hi) begin
            mul_b = subset_reg[63:32];
        end
    end

    assign mul_p    = mul_a * mul_b;
    assign acc_next = cmd.mul_lo ? mul_p[63:32] : acc_reg + mul_p[31:0];

    // Index is the top n+PAD bits of the product; zero when that is no bits
    assign idx_top   = acc_reg[31 -: TABLE_BITS];
    assign idx_shamt = SH_W'(MAX_INDEX_BITS) - SH_W'(n_reg);
    assign idx_calc  = idx_top >> idx_shamt;

    // Scan, subset and multiply registers
    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            magic_reg  <= in_magic;
            rem_reg    <= relevant_mask;
            eff_reg    <= '0;
            n_reg      <= '0;
            subset_reg <= '0;
            j_reg      <= '0;
        end else if (cmd.scan_step) begin
            rem_reg <= rem_reg & ~low_bit;
            eff_reg <= eff_reg | low_bit;
            n_reg   <= n_reg + CNT_W'(1);
        end else if (cmd.subset_adv) begin
            subset_reg <= subset_next;
            j_reg      <= j_reg + MAX_INDEX_BITS'(1);
        end
        if (cmd.mul_lo || cmd.mul_mid || cmd.mul_hi) begin
            acc_reg <= acc_next;
        end
        if (cmd.tbl_rd) begin
            idx_reg <= idx_calc;
        end
    end

    // Stamp and clear address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stamp_reg    <= '0;
            clr_addr_reg <= '0;
        end else begin
            if (cmd.stamp_adv) begin
                stamp_reg <= st.stamp_wrap ? STAMP_WIDTH'(1) : stamp_reg + STAMP_WIDTH'(1);
            end
            if (cmd.clr_step) begin
                clr_addr_reg <= clr_addr_reg + TABLE_BITS'(1);
            end
        end
    end

    // Stamp table: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            tbl_mem[clr_addr_reg] <= '0;
        end else if (cmd.tbl_wr) begin
            tbl_mem[idx_reg] <= stamp_reg;
        end
        if (cmd.tbl_rd) begin
            rd_data_reg <= tbl_mem[idx_calc];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            res_accepted_reg  <= (cmd.res_kind == RES_PASS);
            res_magic_reg     <= (cmd.res_kind == RES_PASS) ? magic_reg : '0;
            res_collision_reg <= (cmd.res_kind == RES_HIT) ? COLL_W'(j_reg) : '0;
        end
    end

    assign res_accepted  = res_accepted_reg;
    assign res_magic     = res_magic_reg;
    assign res_collision = res_collision_reg;

    // Status
    assign st.magic_zero  = (magic_reg == '0);
    assign st.scan_done   = (rem_reg == '0) || (n_reg == CNT_W'(MAX_INDEX_BITS));
    assign st.stamp_wrap  = (stamp_reg == '1);
    assign st.clr_last    = (clr_addr_reg == '1);
    assign st.hit         = (rd_data_reg == stamp_reg);
    assign st.subset_last = (subset_next == '0);

    // A claimed entry never carries the zero stamp of a cleared entry
    a_wr_stamp_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.tbl_wr |-> (stamp_reg != '0))
        else $error("table written with zero stamp");

    // A fresh stamp is never zero
    a_stamp_fresh: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.stamp_adv |=> (stamp_reg != '0))
        else $error("stamp advanced to zero");

    // The subset walk stays inside the effective mask
    a_subset_in_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.subset_adv |=> ((subset_reg & ~eff_reg) == '0))
        else $error("subset left the mask");

endmodule

`default_nettype wire

FILE: sv/mmhv_ctrl.sv
// Controller of the magic multiply hash verifier: sequences the table clear,
// mask scan, per-subset multiply and table check, and the output handshake.
// Depends on mmhv_pkg.
`default_nettype none

module mmhv_ctrl import mmhv_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  wire logic       m_ready,
    input  wire mmhv_stat_t st,
    output mmhv_cmd_t       cmd
);

    localparam logic [3:0] S_CLR_RST  = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_SCAN     = 4'd2;
    localparam logic [3:0] S_STAMP    = 4'd3;
    localparam logic [3:0] S_CLR_WRAP = 4'd4;
    localparam logic [3:0] S_MUL0     = 4'd5;
    localparam logic [3:0] S_MUL1     = 4'd6;
    localparam logic [3:0] S_MUL2     = 4'd7;
    localparam logic [3:0] S_RD       = 4'd8;
    localparam logic [3:0] S_CHK      = 4'd9;
    localparam logic [3:0] S_RESULT   = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [1:0] kind_reg;
    logic [1:0] kind_next;
    logic       m_valid_reg;
    logic       m_valid_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_CLR_RST: begin
                cmd.clr_step = 1'b1;
                if (st.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.item_load = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (st.magic_zero) begin
                    kind_next  = RES_ZERO;
                    state_next = S_RESULT;
                end else if (st.scan_done) begin
                    state_next = S_STAMP;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_STAMP: begin
                cmd.stamp_adv = 1'b1;
                state_next    = st.stamp_wrap ? S_CLR_WRAP : S_MUL0;
            end
            S_CLR_WRAP: begin
                cmd.clr_step = 1'b1;
                if (st.clr_last) begin
                    state_next = S_MUL0;
                end
            end
            S_MUL0: begin
                cmd.mul_lo = 1'b1;
                state_next = S_MUL1;
            end
            S_MUL1: begin
                cmd.mul_mid = 1'b1;
                state_next  = S_MUL2;
            end
            S_MUL2: begin
                cmd.mul_hi = 1'b1;
                state_next = S_RD;
            end
            S_RD: begin
                cmd.tbl_rd = 1'b1;
                state_next = S_CHK;
            end
            S_CHK: begin
                if (st.hit) begin
                    kind_next  = RES_HIT;
                    state_next = S_RESULT;
                end else begin
                    cmd.tbl_wr = 1'b1;
                    if (st.subset_last) begin
                        kind_next  = RES_PASS;
                        state_next = S_RESULT;
                    end else begin
                        cmd.subset_adv = 1'b1;
                        state_next     = S_MUL0;
                    end
                end
            end
            S_RESULT: begin
                // Wait for the output register to be free
                if (!m_valid_reg || m_ready) begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = kind_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared when the transaction completes
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.res_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR_RST;
            kind_reg    <= RES_ZERO;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            kind_reg    <= kind_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_load |-> (!m_valid_reg || m_ready))
        else $error("output register overwritten");

    // One candidate at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second candidate taken while busy");

    // Output valid rises only from the result state
    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_RESULT))
        else $error("output valid raised outside result state");

endmodule

`default_nettype wire

FILE: bench/mmhv_result_checker.sv
// Result checker for the magic multiply hash verifier bench.
// Follows the mask register over APB, predicts each candidate's verdict, compares results.
// Depends on mmhv_pkg for sizes and field widths.
module mmhv_result_checker import mmhv_pkg::*; #(
    parameter logic [3:0] MASK_ADDR = 4'd0
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [63:0]        pwdata,
    input  wire logic [63:0]        prdata,
    input  wire logic               pready,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire logic [MAGIC_W-1:0] s_candidate_magic,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire logic               m_accepted,
    input  wire logic [MAGIC_W-1:0] m_accepted_magic,
    input  wire logic [COLL_W-1:0]  m_collision_subset,
    output int                      fail_count,
    output int                      outstanding
);

    localparam int IDX_BITS = MAX_INDEX_BITS_DEF + PAD_BITS_DEF;
    localparam int SLOTS    = 1 << IDX_BITS;

    typedef struct packed {
        logic               accepted;
        logic [MAGIC_W-1:0] magic;
        logic [COLL_W-1:0]  subset;
    } verdict_t;

    logic [63:0]                mask_q;
    logic [STAMP_WIDTH_DEF-1:0] candidate_stamp;
    logic [STAMP_WIDTH_DEF-1:0] claim_stamp [SLOTS];
    verdict_t                   expected_verdicts [$];
    verdict_t                   want;
    int                         fails;

    // Walk every subset of the used mask bits and look for an index claimed twice
    function automatic verdict_t score_candidate(input logic [MAGIC_W-1:0] magic);
        verdict_t            v;
        int unsigned         sq [MAX_INDEX_BITS_DEF];
        int unsigned         used;
        int unsigned         bits;
        logic [63:0]         subset;
        logic [63:0]         product;
        logic [IDX_BITS-1:0] slot;
        v = '0;
        // zero multiplier: rejected without a scan, stamp untouched
        if (magic == '0)
            return v;
        used = 0;
        for (int b = 0; b < 64; b++) begin
            if (mask_q[b] && used < MAX_INDEX_BITS_DEF) begin
                sq[used] = b;
                used++;
            end
        end
        bits = used + PAD_BITS_DEF;
        // fresh stamp; on wrap the table is wiped and counting restarts at one
        candidate_stamp = candidate_stamp + 1'b1;
        if (candidate_stamp == '0) begin
            foreach (claim_stamp[i])
                claim_stamp[i] = '0;
            candidate_stamp = STAMP_WIDTH_DEF'(1);
        end
        for (int unsigned j = 0; j < (32'd1 << used); j++) begin
            subset = '0;
            for (int unsigned k = 0; k < used; k++) begin
                if (j[k])
                    subset[sq[k]] = 1'b1;
            end
            product = magic * subset;
            slot    = (bits == 0) ? '0 : IDX_BITS'(product >> (64 - bits));
            if (claim_stamp[slot] == candidate_stamp) begin
                v.subset = COLL_W'(j);
                return v;
            end
            claim_stamp[slot] = candidate_stamp;
        end
        v.accepted = 1'b1;
        v.magic    = magic;
        return v;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            mask_q          = '0;
            candidate_stamp = '0;
            foreach (claim_stamp[i])
                claim_stamp[i] = '0;
            expected_verdicts.delete();
            fails = 0;
        end else begin
            // register access: track writes, check read-back
            if (psel && penable && pready && paddr == MASK_ADDR) begin
                if (pwrite) begin
                    mask_q = pwdata;
                end else if (prdata !== mask_q) begin
                    $display("%0t: mask read-back expected %h actual %h",
                             $time, mask_q, prdata);
                    fails++;
                end
            end
            // result transaction against the oldest prediction
            if (m_valid && m_ready) begin
                if (expected_verdicts.size() == 0) begin
                    $display("%0t: unexpected result expected none actual %b/%h/%h", $time,
                             m_accepted, m_accepted_magic, m_collision_subset);
                    fails++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (m_accepted !== want.accepted) begin
                        $display("%0t: accepted expected %b actual %b",
                                 $time, want.accepted, m_accepted);
                        fails++;
                    end
                    if (m_accepted_magic !== want.magic) begin
                        $display("%0t: accepted_magic expected %h actual %h",
                                 $time, want.magic, m_accepted_magic);
                        fails++;
                    end
                    if (m_collision_subset !== want.subset) begin
                        $display("%0t: collision_subset expected %h actual %h",
                                 $time, want.subset, m_collision_subset);
                        fails++;
                    end
                end
            end
            // candidate transaction
            if (s_valid && s_ready)
                expected_verdicts.push_back(score_candidate(s_candidate_magic));
        end
        fail_count  <= fails;
        outstanding <= expected_verdicts.size();
    end

endmodule

FILE: bench/testbench.sv
// Top of the magic multiply hash verifier bench: clock, reset, stimulus and verdict.
// Instantiates the block and mmhv_result_checker; depends on mmhv_pkg.
module testbench;
    import mmhv_pkg::*;

    localparam logic [3:0] MASK_ADDR     = 4'd0;
    localparam int         CYCLE_LIMIT   = 2_000_000;
    localparam int         RANDOM_PHASES = 10;
    localparam int         PHASE_ITEMS   = 14;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;

    logic               aclk;
    logic               aresetn;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [63:0]        pwdata;
    logic [63:0]        prdata;
    logic               pready;
    logic               s_valid;
    logic               s_ready;
    logic [MAGIC_W-1:0] s_candidate_magic;
    logic               m_valid;
    logic               m_ready;
    logic               m_accepted;
    logic [MAGIC_W-1:0] m_accepted_magic;
    logic [COLL_W-1:0]  m_collision_subset;

    int                 check_fails;
    int                 check_pending;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    int unsigned        cycle_count;

    magic_multiply_hash_verifier dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_candidate_magic  (s_candidate_magic),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_accepted         (m_accepted),
        .m_accepted_magic   (m_accepted_magic),
        .m_collision_subset (m_collision_subset)
    );

    mmhv_result_checker #(.MASK_ADDR(MASK_ADDR)) verdict_check (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_candidate_magic  (s_candidate_magic),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_accepted         (m_accepted),
        .m_accepted_magic   (m_accepted_magic),
        .m_collision_subset (m_collision_subset),
        .fail_count         (check_fails),
        .outstanding        (check_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Result side back-pressure
    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Run guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("magic_multiply_hash_verifier verification failed");
            $finish;
        end
    end

    task automatic pick_idling(input idling_t mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct  = 76;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct  = 0;
                recv_stall_pct = 76;
            end
            default: begin
                send_idle_pct  = 11;
                recv_stall_pct = 11;
            end
        endcase
    endtask

    // Setup then access phase; pready ends the access
    task automatic apb_access(input logic write_en, input logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write_en;
        paddr   <= MASK_ADDR;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_mask(input logic [63:0] value);
        apb_access(1'b1, value);
        apb_access(1'b0, '0);
    endtask

    // Valid is only dropped when a gap is taken, so back-to-back transactions keep it high
    task automatic send_candidate(input logic [MAGIC_W-1:0] magic);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_candidate_magic <= magic;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Hold off until every verdict is back, then let the block go quiet
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (check_pending != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        logic [63:0] mask_v;
        logic [63:0] line_magic;
        logic [63:0] magic_v;
        bit          contiguous;
        int          width_n;
        int          base_p;
        int          phase_items;
        int          pick;

        aresetn           <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        s_valid           <= 1'b0;
        s_candidate_magic <= '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        line_magic     = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty mask: one subset, every nonzero candidate passes; zero is refused
        pick_idling(IDLE_NONE);
        set_mask(64'h0);
        send_candidate(64'h0);
        send_candidate(64'h1);
        send_candidate('1);
        send_candidate(64'h8000_0000_0000_0000);
        settle();

        // Low twelve squares: a single-bit multiplier maps subsets one to one
        set_mask(64'hFFF);
        send_candidate(64'h1 << 52);
        send_candidate(64'h0);
        send_candidate('1);
        send_candidate({$urandom, $urandom});
        settle();

        // Over-wide mask: only the lowest twelve set bits take part
        pick_idling(IDLE_BOTH);
        set_mask('1);
        send_candidate(64'h1 << 52);
        send_candidate({$urandom, $urandom});
        settle();

        // Top square alone: odd multipliers pass, even ones collide on subset one
        pick_idling(IDLE_RECEIVER);
        set_mask(64'h8000_0000_0000_0000);
        send_candidate(64'h1);
        send_candidate(64'h2);
        send_candidate('1);
        settle();

        // Top twelve squares
        pick_idling(IDLE_SENDER);
        set_mask(64'hFFF0_0000_0000_0000);
        send_candidate(64'h1);
        send_candidate(64'h1000);
        settle();

        // Random phases: fresh mask and idling pattern each time
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            pick_idling(idling_t'(ph % 4));
            phase_items = PHASE_ITEMS;
            if (ph == RANDOM_PHASES - 1) begin
                // dense board mask, clipped to twelve bits; long scans, so kept short
                contiguous  = 1'b0;
                mask_v      = {$urandom, $urandom};
                phase_items = 6;
            end else begin
                width_n    = $urandom_range(1, 8);
                base_p     = $urandom_range(0, 64 - width_n);
                contiguous = $urandom_range(1);
                if (contiguous) begin
                    mask_v     = ((64'h1 << width_n) - 1) << base_p;
                    line_magic = 64'h1 << (64 - width_n - base_p);
                end else begin
                    mask_v = '0;
                    while ($countones(mask_v) < width_n)
                        mask_v[$urandom_range(63)] = 1'b1;
                end
            end
            set_mask(mask_v);
            repeat (phase_items) begin
                pick = $urandom_range(19);
                if (pick == 0)
                    magic_v = '0;
                else if (pick <= 8)
                    magic_v = contiguous ? line_magic
                                         : {$urandom, $urandom} & {$urandom, $urandom}
                                           & {$urandom, $urandom};
                else if (pick <= 11)
                    magic_v = contiguous ? line_magic ^ (64'h1 << $urandom_range(63))
                                         : {$urandom, $urandom} & {$urandom, $urandom};
                else
                    magic_v = {$urandom, $urandom};
                send_candidate(magic_v);
            end
            settle();
        end

        repeat (20) @(posedge aclk);
        if (check_fails == 0 && check_pending == 0) begin
            $display("magic_multiply_hash_verifier verification clean");
        end else begin
            $display("magic_multiply_hash_verifier verification failed");
        end
        $finish;
    end

endmodule
